### design/fsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_pkg: shared types and constants of the format specification parser
// Phase codes, flag bit positions, character codes and the conversion
// character lookup used by the parse step and the top level.
// ----------------------------------------------------------------------------
package fsp_pkg;

    // Default width of the width and precision counters.
    localparam int COUNT_BITS_DEF = 16;

    localparam int FLAG_BITS = 6;
    localparam int FIELD_BITS = 16;
    localparam int TYPE_BITS = 4;

    // Flag bit positions.
    localparam int F_MINUS = 0;
    localparam int F_ZERO  = 1;
    localparam int F_SPACE = 2;
    localparam int F_HASH  = 3;
    localparam int F_PLUS  = 4;
    localparam int F_DOT   = 5;

    // Character codes.
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_C       = 8'h63;
    localparam logic [7:0] CH_S       = 8'h73;
    localparam logic [7:0] CH_P       = 8'h70;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_I       = 8'h69;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] CH_X_LOW   = 8'h78;
    localparam logic [7:0] CH_X_UP    = 8'h58;
    localparam logic [7:0] CH_PERCENT = 8'h25;

    // Conversion type indexes, in the order of "cspdiuxX%".
    localparam logic [TYPE_BITS-1:0] TY_C         = 4'd0;
    localparam logic [TYPE_BITS-1:0] TY_S         = 4'd1;
    localparam logic [TYPE_BITS-1:0] TY_P         = 4'd2;
    localparam logic [TYPE_BITS-1:0] TY_D         = 4'd3;
    localparam logic [TYPE_BITS-1:0] TY_I         = 4'd4;
    localparam logic [TYPE_BITS-1:0] TY_U         = 4'd5;
    localparam logic [TYPE_BITS-1:0] TY_X_LOW     = 4'd6;
    localparam logic [TYPE_BITS-1:0] TY_X_UP      = 4'd7;
    localparam logic [TYPE_BITS-1:0] TY_PERCENT   = 4'd8;
    localparam logic [TYPE_BITS-1:0] TY_NOT_FOUND = 4'd9;

    typedef enum logic [2:0] {
        PH_FLAGS  = 3'd0,
        PH_WDIG   = 3'd1,
        PH_DOT    = 3'd2,
        PH_PSTART = 3'd3,
        PH_PDIG   = 3'd4,
        PH_TYPE   = 3'd5
    } t_phase;

    typedef logic [FLAG_BITS-1:0] t_flags;

    // One finished specification.
    typedef struct packed {
        logic [TYPE_BITS-1:0]  type_index;
        logic [FIELD_BITS-1:0] precision_value;
        logic [FIELD_BITS-1:0] field_width;
        t_flags                flag_bits;
    } t_spec_result;

    function automatic logic [TYPE_BITS-1:0] conv_index(input logic [7:0] c);
        logic [TYPE_BITS-1:0] t;
        case (c)
            CH_C:       t = TY_C;
            CH_S:       t = TY_S;
            CH_P:       t = TY_P;
            CH_D:       t = TY_D;
            CH_I:       t = TY_I;
            CH_U:       t = TY_U;
            CH_X_LOW:   t = TY_X_LOW;
            CH_X_UP:    t = TY_X_UP;
            CH_PERCENT: t = TY_PERCENT;
            default:    t = TY_NOT_FOUND;
        endcase
        return t;
    endfunction

endpackage

### design/fsp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_step: one character of the parse
// Combinational update of the parse state for one character, plus the
// finished specification when the character ends it.
// ----------------------------------------------------------------------------
module fsp_step #(
    parameter int COUNT_BITS = fsp_pkg::COUNT_BITS_DEF
) (
    input  logic                       i_start,
    input  logic [7:0]                 i_char,
    input  logic [31:0]                i_star,
    input  fsp_pkg::t_phase            i_phase,
    input  fsp_pkg::t_flags            i_flags,
    input  logic [COUNT_BITS-1:0]      i_width,
    input  logic [COUNT_BITS-1:0]      i_prec,
    output fsp_pkg::t_phase            o_phase,
    output fsp_pkg::t_flags            o_flags,
    output logic [COUNT_BITS-1:0]      o_width,
    output logic [COUNT_BITS-1:0]      o_prec,
    output logic                       o_done,
    output fsp_pkg::t_spec_result      o_result
);

    localparam int AW = COUNT_BITS + 4;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    fsp_pkg::t_phase       ph;
    fsp_pkg::t_flags       fl;
    fsp_pkg::t_flags       fl_out;
    logic [COUNT_BITS-1:0] wd;
    logic [COUNT_BITS-1:0] pr;
    logic                  hit;
    logic                  neg;
    logic                  is_dig;
    logic [3:0]            dig;
    logic [31:0]           mag;
    logic [COUNT_BITS-1:0] mag_sat;
    logic [31:0]           wd_ext;
    logic [31:0]           pr_ext;

    // acc * 10 + d, saturated at the counter maximum.
    function automatic logic [COUNT_BITS-1:0] acc_digit(
        input logic [COUNT_BITS-1:0] acc,
        input logic [3:0]            d
    );
        logic [AW-1:0] t;
        t = (AW'(acc) << 3) + (AW'(acc) << 1) + AW'(d);
        return (t[AW-1:COUNT_BITS] != '0) ? CNT_MAX : t[COUNT_BITS-1:0];
    endfunction

    always_comb begin
        neg     = i_star[31];
        mag     = neg ? (~i_star + 32'd1) : i_star;
        mag_sat = (mag[31:COUNT_BITS] != '0) ? CNT_MAX : mag[COUNT_BITS-1:0];
        is_dig  = (i_char >= fsp_pkg::CH_ZERO) && (i_char <= fsp_pkg::CH_NINE);
        dig     = 4'(i_char - fsp_pkg::CH_ZERO);

        ph  = i_start ? fsp_pkg::PH_FLAGS : i_phase;
        fl  = i_start ? '0 : i_flags;
        wd  = i_start ? '0 : i_width;
        pr  = i_start ? '0 : i_prec;
        hit = 1'b0;

        if (ph == fsp_pkg::PH_FLAGS) begin
            hit = 1'b1;
            case (i_char)
                fsp_pkg::CH_MINUS: fl[fsp_pkg::F_MINUS] = 1'b1;
                fsp_pkg::CH_ZERO:  fl[fsp_pkg::F_ZERO]  = 1'b1;
                fsp_pkg::CH_SPACE: fl[fsp_pkg::F_SPACE] = 1'b1;
                fsp_pkg::CH_HASH:  fl[fsp_pkg::F_HASH]  = 1'b1;
                fsp_pkg::CH_PLUS:  fl[fsp_pkg::F_PLUS]  = 1'b1;
                fsp_pkg::CH_STAR: begin
                    wd = mag_sat;
                    if (neg) begin
                        fl[fsp_pkg::F_MINUS] = 1'b1;
                    end
                    ph = fsp_pkg::PH_DOT;
                end
                default: begin
                    hit = 1'b0;
                    ph  = fsp_pkg::PH_WDIG;
                end
            endcase
        end

        if (!hit && ph == fsp_pkg::PH_WDIG) begin
            if (is_dig) begin
                wd  = acc_digit(wd, dig);
                hit = 1'b1;
            end else begin
                ph = fsp_pkg::PH_DOT;
            end
        end

        // A non-dot character here ends the specification; the phase stays
        // at dot, so none of the later checks match.
        if (!hit && ph == fsp_pkg::PH_DOT && i_char == fsp_pkg::CH_DOT) begin
            fl[fsp_pkg::F_DOT] = 1'b1;
            ph  = fsp_pkg::PH_PSTART;
            hit = 1'b1;
        end

        if (!hit && ph == fsp_pkg::PH_PSTART) begin
            if (i_char == fsp_pkg::CH_STAR) begin
                if (neg) begin
                    pr = '0;
                    fl[fsp_pkg::F_DOT] = 1'b0;
                end else begin
                    pr = mag_sat;
                end
                ph  = fsp_pkg::PH_TYPE;
                hit = 1'b1;
            end else begin
                ph = fsp_pkg::PH_PDIG;
            end
        end

        if (!hit && ph == fsp_pkg::PH_PDIG && is_dig) begin
            pr  = acc_digit(pr, dig);
            hit = 1'b1;
        end

        fl_out = fl;
        if (fl[fsp_pkg::F_MINUS]) begin
            fl_out[fsp_pkg::F_ZERO] = 1'b0;
        end
        wd_ext = 32'(wd);
        pr_ext = 32'(pr);

        o_done                   = !hit;
        o_result.flag_bits       = fl_out;
        o_result.field_width     = wd_ext[fsp_pkg::FIELD_BITS-1:0];
        o_result.precision_value = pr_ext[fsp_pkg::FIELD_BITS-1:0];
        o_result.type_index      = fsp_pkg::conv_index(i_char);

        // A finished specification returns everything to its reset values.
        o_phase = hit ? ph : fsp_pkg::PH_FLAGS;
        o_flags = hit ? fl : '0;
        o_width = hit ? wd : '0;
        o_prec  = hit ? pr : '0;
    end

endmodule

### design/format_spec_parser_top.sv
`timescale 1ns / 1ps
// The word carrying the conversion character is captured in the input register; the step
// logic then ends the specification and the result is written into the result register.
// Throughput: one format character per cycle; the parse state feeds back through a single
// step of logic. Words only wait when a result is held and the next character also ends one.
// Reset (i_rst_n low, synchronous) empties both register stages and returns
// the parser to the flags phase with no flags, width or precision.
// ----------------------------------------------------------------------------
// format_spec_parser_top: streaming printf conversion specification parser
// Accepts the characters following a percent sign, one per word, and emits
// one word of flags, width, precision and conversion type per specification.
// ----------------------------------------------------------------------------
module format_spec_parser_top #(
    parameter int COUNT_BITS = fsp_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] char_code, [39:8] star_value (signed)
    input  logic [39:0] s_axis_tdata,
    // [0] start_req
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] flag_bits, [21:6] field_width, [37:22] precision_value,
    // [41:38] type_index, [47:42] zero
    output logic [47:0] m_axis_tdata
);

    // Input register: holds the character being worked on this cycle.
    logic        r_in_valid;
    logic        r_in_start;
    logic [7:0]  r_in_char;
    logic [31:0] r_in_star;

    // Parse state carried from one character to the next.
    fsp_pkg::t_phase       r_phase;
    fsp_pkg::t_flags       r_flags;
    logic [COUNT_BITS-1:0] r_width;
    logic [COUNT_BITS-1:0] r_prec;

    // Result register toward the master side.
    logic                  r_out_valid;
    fsp_pkg::t_spec_result r_out;

    fsp_pkg::t_phase       n_phase;
    fsp_pkg::t_flags       n_flags;
    logic [COUNT_BITS-1:0] n_width;
    logic [COUNT_BITS-1:0] n_prec;
    logic                  step_done;
    fsp_pkg::t_spec_result step_result;

    logic out_free;
    logic advance;

    fsp_step #(
        .COUNT_BITS(COUNT_BITS)
    ) u_step (
        .i_start  (r_in_start),
        .i_char   (r_in_char),
        .i_star   (r_in_star),
        .i_phase  (r_phase),
        .i_flags  (r_flags),
        .i_width  (r_width),
        .i_prec   (r_prec),
        .o_phase  (n_phase),
        .o_flags  (n_flags),
        .o_width  (n_width),
        .o_prec   (n_prec),
        .o_done   (step_done),
        .o_result (step_result)
    );

    // The held character moves on when it needs no result slot, or when the
    // result register is empty or being emptied this cycle.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && (!step_done || out_free);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_start <= s_axis_tuser[0];
            r_in_char  <= s_axis_tdata[7:0];
            r_in_star  <= s_axis_tdata[39:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= fsp_pkg::PH_FLAGS;
            r_flags <= '0;
            r_width <= '0;
            r_prec  <= '0;
        end else if (advance) begin
            r_phase <= n_phase;
            r_flags <= n_flags;
            r_width <= n_width;
            r_prec  <= n_prec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && step_done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_done) begin
            r_out <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out};

    // Reset leaves the parser in the flags phase with cleared counters.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_phase == fsp_pkg::PH_FLAGS && r_width == '0 && r_prec == '0))
        else $error("parse state not cleared by reset");

    // A finished specification clears the parse state behind it.
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && step_done) |=> (r_phase == fsp_pkg::PH_FLAGS && r_flags == '0
                                    && r_width == '0 && r_prec == '0))
        else $error("parse state survived a finished specification");

    // A character that waits must not change the parse state.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> ($stable(r_phase) && $stable(r_width)
                                      && $stable(r_prec) && $stable(r_flags)))
        else $error("parse state moved while the character stalled");

    // Minus always overrides zero, and the type index stays in its range.
    a_result_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!(r_out.flag_bits[fsp_pkg::F_MINUS]
                           && r_out.flag_bits[fsp_pkg::F_ZERO])
                         && r_out.type_index <= fsp_pkg::TY_NOT_FOUND))
        else $error("illegal result word");

    // A result that is not taken is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !(advance && step_done))
        else $error("pending result overwritten");

endmodule
